FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Map geometry, operation and status codes, beat formats of both channels.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Volume geometry
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_W     = 64;                        // map bits per memory word
  localparam int N_WORDS    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W     = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
  localparam int WBIT_W     = $clog2(WORD_W);
  localparam int NUM_W      = WIDX_W + WBIT_W;           // internal block number width
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);    // holds a block count

  // Field widths fixed by the channel format
  localparam int BLK_W      = 12;
  localparam int TOTAL_W    = 13;
  localparam int DSTART_W   = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_OUT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] allocated_block;
    logic [BLK_W-1:0] free_count;
  } out_item_t;

endpackage

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top: first-fit block allocator over a usage bitmap
// Allocate / free / mark blocks; one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_valid/in_data, held off by in_stall. Each beat
//   carries an op (allocate, free, mark) and a block number. Every accepted
//   beat yields exactly one result beat on out_valid/out_data: a status, the
//   block handed out by an allocate and the free block count after the op.
//   The map lives in a 64-bit wide word RAM (one read, one write port) next to
//   a per-word "full" summary in flops, so allocate finds its word without a
//   scan. Each request passes through accept, word select plus RAM read, then
//   modify plus write back plus result load; one request is in flight at a
//   time, so a new request is taken only once the last one has loaded its
//   result.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and parks in its modify step until the old beat leaves.
//   Reset clears the map at once through per-word valid bits (no clearing
//   pass), zeroes the used count and loads a volume size of 4096 blocks and
//   data_start = 1.
//   Write cfg_* only while idle; writes take effect on the next request.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bba_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output bba_pkg::out_item_t            out_data,
  // configuration
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_MOD
  } state_t;

  state_t                              state_r, state_nxt;
  bba_pkg::in_item_t                   item_r;
  logic [bba_pkg::WIDX_W-1:0]          widx_r;
  logic                                wfound_r;
  logic                                rvalid_r;
  logic [bba_pkg::TOTAL_W-1:0]         total_r;
  logic [bba_pkg::DSTART_W-1:0]        dstart_r;
  logic [bba_pkg::CNT_W-1:0]           used_r, used_nxt;
  logic [bba_pkg::N_WORDS-1:0]         wvalid_r;
  logic [bba_pkg::N_WORDS-1:0]         full_r;
  logic                                out_valid_r;
  bba_pkg::out_item_t                  out_data_r;

  logic                                accept;
  logic                                fire;
  logic [bba_pkg::CNT_W-1:0]           eff_total;
  logic [bba_pkg::CNT_W-1:0]           avail;

  // word select for allocate
  logic [bba_pkg::WIDX_W-1:0]          find_idx;
  logic                                find_ok;
  logic [bba_pkg::WIDX_W-1:0]          raddr;

  // modify step
  logic [bba_pkg::WORD_W-1:0]          rdata;
  logic [bba_pkg::WORD_W-1:0]          cur_word;
  logic [bba_pkg::WORD_W-1:0]          w0_mask;
  logic [bba_pkg::WORD_W-1:0]          busy_word;
  logic [bba_pkg::WORD_W-1:0]          new_word;
  logic [bba_pkg::WBIT_W-1:0]          zbit;
  logic                                zfound;
  logic [bba_pkg::WBIT_W-1:0]          sel_bit;
  logic [bba_pkg::NUM_W-1:0]           cand;
  logic [bba_pkg::CNT_W-1:0]           blk_ext;
  logic                                cur_bit;
  logic                                changed;
  logic                                cnt_inc;
  logic                                cnt_dec;
  bba_pkg::status_t                    status;
  logic [bba_pkg::BLK_W-1:0]           given;
  logic [bba_pkg::CNT_W-1:0]           free_full;
  logic [bba_pkg::BLK_W-1:0]           free_sat;
  logic                                new_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fire     = (state_r == S_MOD) && (!out_valid_r || !out_stall);

  // Clamp the configured total to the map size.
  assign eff_total = (total_r > bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS))
                   ? bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)
                   : bba_pkg::CNT_W'(total_r);
  // Block 0 is never counted as available.
  assign avail = (eff_total == '0) ? '0 : eff_total - bba_pkg::CNT_W'(1);

  // Lowest word that still has a clear bit.
  always_comb begin
    find_idx = '0;
    find_ok  = 1'b0;
    for (int i = bba_pkg::N_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        find_idx = bba_pkg::WIDX_W'(i);
        find_ok  = 1'b1;
      end
    end
  end

  assign raddr = (item_r.op == bba_pkg::OP_ALLOC)
               ? find_idx
               : item_r.block_number[bba_pkg::NUM_W-1:bba_pkg::WBIT_W];

  bba_ram #(
    .DEPTH (bba_pkg::N_WORDS),
    .WIDTH (bba_pkg::WORD_W)
  ) u_map (
    .clk   (clk),
    .we    (fire && changed),
    .waddr (widx_r),
    .wdata (new_word),
    .re    (state_r == S_FIND),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A word never written since reset reads as all clear.
  assign cur_word  = rvalid_r ? rdata : '0;
  // Treat block 0 as taken so it is never handed out or counted.
  assign w0_mask   = (widx_r == '0) ? bba_pkg::WORD_W'(1) : '0;
  assign busy_word = cur_word | w0_mask;
  assign sel_bit   = item_r.block_number[bba_pkg::WBIT_W-1:0];
  assign cur_bit   = cur_word[sel_bit];
  assign blk_ext   = bba_pkg::CNT_W'(item_r.block_number);

  always_comb begin
    zbit   = '0;
    zfound = 1'b0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!busy_word[i]) begin
        zbit   = bba_pkg::WBIT_W'(i);
        zfound = 1'b1;
      end
    end
  end

  assign cand = {widx_r, zbit};

  always_comb begin
    new_word = cur_word;
    changed  = 1'b0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    status   = bba_pkg::ST_OK;
    given    = '0;
    case (item_r.op)
      bba_pkg::OP_ALLOC: begin
        // Every lower block is taken, so a clear bit at or past the total fails.
        if (wfound_r && zfound && (bba_pkg::CNT_W'(cand) < eff_total)) begin
          new_word[zbit] = 1'b1;
          changed        = 1'b1;
          cnt_inc        = 1'b1;
          given          = bba_pkg::BLK_W'(cand);
        end else begin
          status = bba_pkg::ST_NO_FREE;
        end
      end
      bba_pkg::OP_FREE: begin
        if ((item_r.block_number < dstart_r) || (blk_ext >= eff_total)) begin
          status = bba_pkg::ST_OUT_RANGE;
        end else if (cur_bit) begin
          new_word[sel_bit] = 1'b0;
          changed           = 1'b1;
          cnt_dec           = 1'b1;
        end
      end
      bba_pkg::OP_MARK: begin
        if (blk_ext >= eff_total) begin
          status = bba_pkg::ST_OUT_RANGE;
        end else if ((item_r.block_number != '0) && !cur_bit) begin
          new_word[sel_bit] = 1'b1;
          changed           = 1'b1;
          cnt_inc           = 1'b1;
        end
      end
      default: begin
        // unused op: no change, plain ok
      end
    endcase
  end

  assign new_full = &(new_word | w0_mask);

  always_comb begin
    used_nxt = used_r;
    if (cnt_inc) begin
      used_nxt = used_r + bba_pkg::CNT_W'(1);
    end else if (cnt_dec) begin
      used_nxt = used_r - bba_pkg::CNT_W'(1);
    end
  end

  // Free count after this op, floored at zero and capped at the field width.
  assign free_full = (avail > used_nxt) ? avail - used_nxt : '0;
  assign free_sat  = (free_full > bba_pkg::CNT_W'({bba_pkg::BLK_W{1'b1}}))
                   ? {bba_pkg::BLK_W{1'b1}}
                   : free_full[bba_pkg::BLK_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_FIND;
      S_FIND: state_nxt = S_MOD;
      S_MOD:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= bba_pkg::TOTAL_W'(4096);
      dstart_r    <= bba_pkg::DSTART_W'(1);
      used_r      <= '0;
      wvalid_r    <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::CFG_VOL_SIZE:   total_r  <= cfg_wdata;
          bba_pkg::CFG_DATA_START: dstart_r <= cfg_wdata[bba_pkg::DSTART_W-1:0];
          default: ;
        endcase
      end

      if (fire && changed) begin
        wvalid_r[widx_r] <= 1'b1;
        full_r[widx_r]   <= new_full;
        used_r           <= used_nxt;
      end

      // Load on fire, drop once the waiting beat is taken.
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == S_FIND) begin
      widx_r   <= raddr;
      wfound_r <= (item_r.op == bba_pkg::OP_ALLOC) ? find_ok : 1'b1;
      rvalid_r <= wvalid_r[raddr];
    end
    if (fire) begin
      out_data_r.status          <= status;
      out_data_r.allocated_block <= given;
      out_data_r.free_count      <= free_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS - 1))
    else $error("used count beyond map size");

  a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.allocated_block != '0)) |->
      (out_data_r.status == bba_pkg::ST_OK))
    else $error("block handed out with failing status");

  a_summary_track: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && changed) |=> (full_r[$past(widx_r)] == $past(new_full)))
    else $error("full summary out of step with written word");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && changed) |=> ((used_r == $past(used_r) + bba_pkg::CNT_W'(1)) ||
                           (used_r == $past(used_r) - bba_pkg::CNT_W'(1))))
    else $error("used count moved by other than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fire)
    else $error("result loaded over a waiting beat");

endmodule
